// ===== hdl/fifo_with_remove_and_high_water_defines.svh =====
// ----------------------------------------------------------------------------
// fifo_with_remove_and_high_water assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_REMOVE_AND_HIGH_WATER_DEFINES_SVH
`define FIFO_WITH_REMOVE_AND_HIGH_WATER_DEFINES_SVH

// same-cycle implication
`define FRHW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FRHW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fifo_rhw_pkg.sv =====
// ----------------------------------------------------------------------------
// fifo_rhw_pkg
// Types, sizes and codes shared by the queue controller and its top level.
// ----------------------------------------------------------------------------
package fifo_rhw_pkg;

  localparam int DEPTH       = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PORT_WORD_W = 32;
  localparam int PORT_CNT_W  = 5;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [1:0] STAT_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]             op;
    logic [PORT_WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [PORT_WORD_W-1:0] popped;
    logic [1:0]             status;
    logic [PORT_CNT_W-1:0]  occupancy;
    logic [PORT_CNT_W-1:0]  high_water;
  } res_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

endpackage

// ===== hdl/fifo_rhw_ram.sv =====
// ----------------------------------------------------------------------------
// fifo_rhw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fifo_rhw_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32,
  parameter int ADDR_P  = $clog2(DEPTH_P)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [ADDR_P-1:0]  waddr,
  input  logic [WIDTH_P-1:0] wdata,
  input  logic [ADDR_P-1:0]  raddr,
  output logic [WIDTH_P-1:0] rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fifo_rhw_ctrl.sv =====
// ----------------------------------------------------------------------------
// fifo_rhw_ctrl
// Sequencer for push, pop and remove; head, fill and peak counters; the
// remove scan and the compaction pass that moves later entries toward the head.
// ----------------------------------------------------------------------------
module fifo_rhw_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  fifo_rhw_pkg::cmd_t     cmd,
  output logic                   done_valid,
  input  logic                   done_take,
  output fifo_rhw_pkg::res_t     done,
  output fifo_rhw_pkg::mem_req_t mem_req,
  input  fifo_rhw_pkg::word_t    mem_rdata
);

  fifo_rhw_pkg::state_t state, state_next;
  fifo_rhw_pkg::addr_t  head, head_next;
  fifo_rhw_pkg::cnt_t   fill, fill_next;
  fifo_rhw_pkg::cnt_t   peak, peak_next;
  fifo_rhw_pkg::cnt_t   idx, idx_next;
  fifo_rhw_pkg::word_t  key, key_next;
  fifo_rhw_pkg::word_t  res_popped, res_popped_next;
  logic [1:0]           res_status, res_status_next;

  fifo_rhw_pkg::cnt_t   fill_inc;
  fifo_rhw_pkg::cnt_t   idx_1;
  fifo_rhw_pkg::cnt_t   idx_2;

  // circular slot at offset from the head, offset below DEPTH
  function automatic fifo_rhw_pkg::addr_t slot(fifo_rhw_pkg::addr_t base,
                                               fifo_rhw_pkg::addr_t off);
    logic [fifo_rhw_pkg::ADDR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (fifo_rhw_pkg::ADDR_W + 1)'(fifo_rhw_pkg::DEPTH)) begin
      sum = sum - (fifo_rhw_pkg::ADDR_W + 1)'(fifo_rhw_pkg::DEPTH);
    end
    return sum[fifo_rhw_pkg::ADDR_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fifo_rhw_pkg::S_IDLE;
      head  <= '0;
      fill  <= '0;
      peak  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      fill  <= fill_next;
      peak  <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    key        <= key_next;
    res_popped <= res_popped_next;
    res_status <= res_status_next;
  end

  assign fill_inc = fill + 1'b1;
  assign idx_1    = idx + 1'b1;
  assign idx_2    = idx + 2'd2;

  always_comb begin
    state_next      = state;
    head_next       = head;
    fill_next       = fill;
    peak_next       = peak;
    idx_next        = idx;
    key_next        = key;
    res_popped_next = res_popped;
    res_status_next = res_status;
    mem_req.we      = 1'b0;
    mem_req.waddr   = slot(head, idx[fifo_rhw_pkg::ADDR_W-1:0]);
    mem_req.wdata   = mem_rdata;
    mem_req.raddr   = head;
    cmd_stall       = (state != fifo_rhw_pkg::S_IDLE);
    done_valid      = (state == fifo_rhw_pkg::S_DONE);

    case (state)
      fifo_rhw_pkg::S_IDLE: begin
        if (cmd_valid) begin
          key_next        = fifo_rhw_pkg::word_t'(cmd.word);
          res_popped_next = '0;
          res_status_next = fifo_rhw_pkg::STAT_OK;
          idx_next        = '0;
          state_next      = fifo_rhw_pkg::S_DONE;
          case (cmd.op)
            fifo_rhw_pkg::OP_PUSH: begin
              if (fill == fifo_rhw_pkg::CNT_W'(fifo_rhw_pkg::DEPTH)) begin
                res_status_next = fifo_rhw_pkg::STAT_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = slot(head, fill[fifo_rhw_pkg::ADDR_W-1:0]);
                mem_req.wdata = fifo_rhw_pkg::word_t'(cmd.word);
                fill_next     = fill_inc;
                if (fill_inc > peak) begin
                  peak_next = fill_inc;
                end
              end
            end
            fifo_rhw_pkg::OP_POP: begin
              if (fill == '0) begin
                res_status_next = fifo_rhw_pkg::STAT_EMPTY;
              end else begin
                state_next = fifo_rhw_pkg::S_POP_RD;
              end
            end
            fifo_rhw_pkg::OP_REMOVE: begin
              if (fill == '0) begin
                res_status_next = fifo_rhw_pkg::STAT_NOT_FOUND;
              end else begin
                state_next = fifo_rhw_pkg::S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      fifo_rhw_pkg::S_POP_RD: begin
        res_popped_next = mem_rdata;
        head_next       = slot(head, fifo_rhw_pkg::ADDR_W'(1));
        fill_next       = fill - 1'b1;
        state_next      = fifo_rhw_pkg::S_DONE;
      end

      // read data holds the entry at offset idx
      fifo_rhw_pkg::S_SCAN: begin
        mem_req.raddr = slot(head, idx_1[fifo_rhw_pkg::ADDR_W-1:0]);
        if (mem_rdata == key) begin
          if (idx_1 < fill) begin
            state_next = fifo_rhw_pkg::S_SHIFT;
          end else begin
            fill_next  = fill - 1'b1;
            state_next = fifo_rhw_pkg::S_DONE;
          end
        end else if (idx_1 < fill) begin
          idx_next = idx_1;
        end else begin
          res_status_next = fifo_rhw_pkg::STAT_NOT_FOUND;
          state_next      = fifo_rhw_pkg::S_DONE;
        end
      end

      // read data holds the entry at offset idx+1, move it down by one;
      // the next read is two slots ahead of the write, so they never collide
      fifo_rhw_pkg::S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = slot(head, idx[fifo_rhw_pkg::ADDR_W-1:0]);
        mem_req.wdata = mem_rdata;
        mem_req.raddr = slot(head, idx_2[fifo_rhw_pkg::ADDR_W-1:0]);
        idx_next      = idx_1;
        if (idx_2 >= fill) begin
          fill_next  = fill - 1'b1;
          state_next = fifo_rhw_pkg::S_DONE;
        end
      end

      fifo_rhw_pkg::S_DONE: begin
        if (done_take) begin
          state_next = fifo_rhw_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = fifo_rhw_pkg::S_IDLE;
      end
    endcase
  end

  assign done.popped     = fifo_rhw_pkg::PORT_WORD_W'(res_popped);
  assign done.status     = res_status;
  assign done.occupancy  = fifo_rhw_pkg::PORT_CNT_W'(fill);
  assign done.high_water = fifo_rhw_pkg::PORT_CNT_W'(peak);

endmodule

// ===== hdl/fifo_with_remove_and_high_water.sv =====
// ----------------------------------------------------------------------------
// fifo_with_remove_and_high_water
// Bounded queue with push, pop, remove-by-value and a high-water mark.
// ----------------------------------------------------------------------------
// Takes one transaction at a time; entries live in a single two-port RAM
// with registered read, so entries are read one at a time. A remove scans
// up to the match, then moves each later entry one slot toward the head to
// close the gap. The next transaction is accepted once the result sits in
// the output register, even while that result is stalled. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
`include "fifo_with_remove_and_high_water_defines.svh"

module fifo_with_remove_and_high_water (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  fifo_rhw_pkg::cmd_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output fifo_rhw_pkg::res_t res
);

  logic                   done_valid;
  logic                   done_take;
  fifo_rhw_pkg::res_t     done;
  fifo_rhw_pkg::mem_req_t mem_req;
  fifo_rhw_pkg::word_t    mem_rdata;

  fifo_rhw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .done_valid (done_valid),
    .done_take  (done_take),
    .done       (done),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata)
  );

  fifo_rhw_ram #(
    .DEPTH_P (fifo_rhw_pkg::DEPTH),
    .WIDTH_P (fifo_rhw_pkg::WORD_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register frees the controller while a result waits downstream
  assign done_take = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done_take) begin
      res_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_take) begin
      res <= done;
    end
  end

  `FRHW_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd_valid && !cmd_stall, cmd_stall, "controller not busy after accepting a transaction")
  `FRHW_ASSERT_NEXT(a_result_lands, clk, rst, done_valid && done_take, res_valid && res == $past(done), "finished result not loaded into output register")
  `FRHW_ASSERT_IMPL(a_peak_bounds, clk, rst, res_valid, (res.occupancy <= res.high_water) && (res.high_water <= fifo_rhw_pkg::PORT_CNT_W'(fifo_rhw_pkg::DEPTH)), "occupancy above high-water mark or depth")
  `FRHW_ASSERT_IMPL(a_full_means_full, clk, rst, res_valid && res.status == fifo_rhw_pkg::STAT_FULL, res.occupancy == fifo_rhw_pkg::PORT_CNT_W'(fifo_rhw_pkg::DEPTH), "full status with free space")

endmodule
